>>> rtl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Display record handed from the front to the back
	typedef struct packed {
		logic             is_tick;
		logic             blank;
		logic [3:0][7:0]  pats;
	} rec_t;

	localparam logic [7:0]  SEG_BLANK   = 8'hFF;
	localparam logic [7:0]  SEG_MINUS   = 8'hBF;
	localparam logic [7:0]  SEG_DP_MASK = 8'h7F;
	localparam logic [7:0]  SEL_NONE    = 8'hFF;

	localparam logic [17:0] INT_MAX     = 18'd9999;
	localparam logic [17:0] THOUSAND    = 18'd1000;
	// floor(x / 1000) = (x * 268436) >> 28, exact for x < 2^18
	localparam logic [18:0] DIV1000_MUL = 19'd268436;
	localparam int          DIV1000_SH  = 28;
	// floor(x / 100) = (x * 41) >> 12, exact for x < 1024
	localparam logic [15:0] DIV100_MUL  = 16'd41;
	localparam int          DIV100_SH   = 12;
	// floor(x / 10) = (x * 205) >> 11, exact for x < 1024
	localparam logic [17:0] DIV10_MUL   = 18'd205;
	localparam int          DIV10_SH    = 11;

	localparam logic [3:0]  DIGIT_MAX   = 4'd9;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0: g = 8'hC0;
			4'd1: g = 8'hF9;
			4'd2: g = 8'hA4;
			4'd3: g = 8'hB0;
			4'd4: g = 8'h99;
			4'd5: g = 8'h92;
			4'd6: g = 8'h82;
			4'd7: g = 8'hF8;
			4'd8: g = 8'h80;
			4'd9: g = 8'h90;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] select_code(input logic [1:0] p);
		logic [7:0] s;
		unique case (p)
			2'd0: s = 8'h7F;
			2'd1: s = 8'hBF;
			2'd2: s = 8'hDF;
			2'd3: s = 8'hEF;
			default: s = SEL_NONE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ssd_front.sv
`default_nettype none

module ssd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               operation,
	input  wire logic signed [17:0] value,
	input  wire logic               decimal_mode,
	output logic                    rec_push,
	input  wire logic               rec_full,
	output ssd_pkg::rec_t           rec
);

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic op_s1, op_s2, op_s3, op_s4, op_s5;
	logic dec_s1, dec_s2, dec_s3, dec_s4, dec_s5;
	logic neg_s2, neg_s3, neg_s4, neg_s5;
	logic [17:0] val_s1;
	logic [17:0] x_s2, x_s3;
	logic [36:0] prod_s3;
	logic [3:0]  q_s4, q_s5;
	logic [9:0]  r_s4, r_s5;
	logic [3:0]  h_s5;
	logic [6:0]  t_s5, u_s5;

	// stage 1: magnitude and integer clamp
	logic        neg1;
	logic [17:0] abs1, clamp1;

	// stage 3: quotient and remainder by 1000
	logic [7:0]  q3;
	logic [17:0] qk3, diff3;
	logic [3:0]  qc3;

	// stage 4: small divisions of the remainder
	logic [15:0] p100;
	logic [17:0] p10, pr10;
	logic [17:0] r5;

	// stage 5: last digits and glyphs
	logic [14:0] tq_p, uq_p;
	logic [3:0]  tq, uq;
	logic [6:0]  t_mod, u_mod;
	logic [9:0]  ones;

	assign adv      = !vld_s5 || !rec_full;
	assign full     = !adv;
	assign rec_push = vld_s5;

	always_comb begin
		neg1   = val_s1[17];
		abs1   = neg1 ? (~val_s1 + 18'd1) : val_s1;
		if (neg1) begin
			clamp1 = '0;
		end else if (val_s1 > ssd_pkg::INT_MAX) begin
			clamp1 = ssd_pkg::INT_MAX;
		end else begin
			clamp1 = val_s1;
		end
	end

	always_comb begin
		q3    = prod_s3[ssd_pkg::DIV1000_SH +: 8];
		qk3   = {10'd0, q3} * ssd_pkg::THOUSAND;
		diff3 = x_s3 - qk3;
		qc3   = (q3 > {4'd0, ssd_pkg::DIGIT_MAX}) ? ssd_pkg::DIGIT_MAX : q3[3:0];
	end

	always_comb begin
		p100 = {6'd0, r_s4} * ssd_pkg::DIV100_MUL;
		p10  = {8'd0, r_s4} * ssd_pkg::DIV10_MUL;
		r5   = {8'd0, r_s4} + 18'd5;
		pr10 = r5 * ssd_pkg::DIV10_MUL;
	end

	always_comb begin
		tq_p  = {8'd0, t_s5} * ssd_pkg::DIV10_MUL[14:0];
		uq_p  = {8'd0, u_s5} * ssd_pkg::DIV10_MUL[14:0];
		tq    = tq_p[ssd_pkg::DIV10_SH +: 4];
		uq    = uq_p[ssd_pkg::DIV10_SH +: 4];
		t_mod = t_s5 - {3'd0, tq} * 7'd10;
		u_mod = u_s5 - {3'd0, uq} * 7'd10;
		ones  = r_s5 - {3'd0, t_s5} * 10'd10;

		rec.is_tick = (op_s5 == ssd_pkg::OP_TICK);
		if (!dec_s5) begin
			rec.blank   = 1'b0;
			rec.pats[3] = ssd_pkg::glyph(q_s5);
			rec.pats[2] = ssd_pkg::glyph(h_s5);
			rec.pats[1] = ssd_pkg::glyph(t_mod[3:0]);
			rec.pats[0] = ssd_pkg::glyph(ones[3:0]);
		end else begin
			rec.blank   = !neg_s5;
			rec.pats[3] = neg_s5 ? ssd_pkg::SEG_MINUS : ssd_pkg::SEG_BLANK;
			rec.pats[2] = ssd_pkg::glyph(q_s5) & ssd_pkg::SEG_DP_MASK;
			rec.pats[1] = ssd_pkg::glyph(h_s5);
			rec.pats[0] = ssd_pkg::glyph(u_mod[3:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= operation;
			val_s1 <= value;
			dec_s1 <= decimal_mode;

			op_s2  <= op_s1;
			dec_s2 <= dec_s1;
			neg_s2 <= neg1;
			x_s2   <= dec_s1 ? abs1 : clamp1;

			op_s3   <= op_s2;
			dec_s3  <= dec_s2;
			neg_s3  <= neg_s2;
			x_s3    <= x_s2;
			prod_s3 <= {19'd0, x_s2} * {18'd0, ssd_pkg::DIV1000_MUL};

			op_s4  <= op_s3;
			dec_s4 <= dec_s3;
			neg_s4 <= neg_s3;
			q_s4   <= qc3;
			r_s4   <= diff3[9:0];

			op_s5  <= op_s4;
			dec_s5 <= dec_s4;
			neg_s5 <= neg_s4;
			q_s5   <= q_s4;
			r_s5   <= r_s4;
			h_s5   <= p100[ssd_pkg::DIV100_SH +: 4];
			t_s5   <= p10[ssd_pkg::DIV10_SH +: 7];
			u_s5   <= pr10[ssd_pkg::DIV10_SH +: 7];
		end
	end

endmodule

`default_nettype wire

>>> rtl/ssd_queue.sv
`default_nettype none

module ssd_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire ssd_pkg::rec_t wdata,
	input  wire logic          pop,
	output logic               empty,
	output ssd_pkg::rec_t      rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssd_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ssd_back.sv
`default_nettype none

module ssd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          dwell_ticks_we,
	input  wire logic [7:0]    dwell_ticks,
	input  wire logic          rec_empty,
	output logic               rec_pop,
	input  wire ssd_pkg::rec_t rec,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         digit_sel,
	output logic [7:0]         segment_bits
);

	logic [3:0][7:0] pats_q;
	logic            blank_q;
	logic [1:0]      pos_q;
	logic [7:0]      cnt_q;
	logic [7:0]      dwell_q;
	logic            out_vld_q;
	logic [7:0]      digit_q, seg_q;

	logic            take;
	logic [3:0][7:0] pats_now;
	logic            blank_now;
	logic [8:0]      cnt_inc;

	assign empty        = !out_vld_q;
	assign digit_sel    = digit_q;
	assign segment_bits = seg_q;
	assign take         = !rec_empty && (!out_vld_q || pop);
	assign rec_pop      = take;

	// a load shows the new patterns in its own result
	always_comb begin
		pats_now  = rec.is_tick ? pats_q : rec.pats;
		blank_now = rec.is_tick ? blank_q : rec.blank;
		cnt_inc   = {1'b0, cnt_q} + 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pats_q    <= {4{ssd_pkg::SEG_BLANK}};
			blank_q   <= 1'b1;
			pos_q     <= 2'd3;
			cnt_q     <= '0;
			dwell_q   <= 8'd1;
			out_vld_q <= 1'b0;
		end else begin
			if (dwell_ticks_we) begin
				dwell_q <= dwell_ticks;
			end
			if (take) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (take && !rec.is_tick) begin
				pats_q  <= rec.pats;
				blank_q <= rec.blank;
			end
			// zero dwell acts as one
			if (take && rec.is_tick) begin
				if (cnt_inc >= {1'b0, dwell_q}) begin
					cnt_q <= '0;
					pos_q <= pos_q - 2'd1;
				end else begin
					cnt_q <= cnt_inc[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == 2'd3 && blank_now) begin
				digit_q <= ssd_pkg::SEL_NONE;
				seg_q   <= ssd_pkg::SEG_BLANK;
			end else begin
				digit_q <= ssd_pkg::select_code(pos_q);
				seg_q   <= pats_now[pos_q];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/seven_segment_scan_driver.sv
`default_nettype none

// Scan driver for a four-digit common-anode seven-segment display. Every item
// gives one item of port bytes: a load (operation 0) stores a new reading and
// shows the current digit with it, a tick (operation 1) shows the current digit
// and then advances the scan 3, 2, 1, 0 after dwell_ticks ticks. Integer mode
// clamps the reading to 0..9999; decimal mode reads thousandths and shows sign,
// one integer digit with the point, and two decimals. One item is taken per
// clock while the front is not stalled by a full queue; the front converts
// through five pipeline stages (one multiply by the reciprocal of 1000, then
// small constant divides), and its result then passes the QUEUE_DEPTH queue
// and the output register. A dwell_ticks write takes effect on the next tick.
module seven_segment_scan_driver #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               operation,
	input  wire logic signed [17:0] value,
	input  wire logic               decimal_mode,
	input  wire logic               dwell_ticks_we,
	input  wire logic [7:0]         dwell_ticks,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              digit_sel,
	output logic [7:0]              segment_bits
);

	ssd_pkg::rec_t front_rec, queue_rec;
	logic          front_push, queue_full;
	logic          queue_empty, queue_pop;

	ssd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.value        (value),
		.decimal_mode (decimal_mode),
		.rec_push     (front_push),
		.rec_full     (queue_full),
		.rec          (front_rec)
	);

	ssd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.full   (queue_full),
		.wdata  (front_rec),
		.pop    (queue_pop),
		.empty  (queue_empty),
		.rdata  (queue_rec)
	);

	ssd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.dwell_ticks_we (dwell_ticks_we),
		.dwell_ticks    (dwell_ticks),
		.rec_empty      (queue_empty),
		.rec_pop        (queue_pop),
		.rec            (queue_rec),
		.pop            (pop),
		.empty          (empty),
		.digit_sel      (digit_sel),
		.segment_bits   (segment_bits)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;

	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 150;

	// active-low glyphs for 0..9 and digit selects for positions 0..3
	localparam logic [9:0][7:0] DIGIT_GLYPH = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
		8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
	localparam logic [3:0][7:0] POS_SELECT = {8'hEF, 8'hDF, 8'hBF, 8'h7F};

	typedef struct {
		ssd_pkg::op_t       op;
		logic signed [17:0] val;
		logic               dec;
	} display_cmd_t;

	typedef struct {
		logic [7:0] dig;
		logic [7:0] seg;
	} port_bytes_t;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               push           = 1'b0;
	logic               operation      = 1'b0;
	logic signed [17:0] value          = '0;
	logic               decimal_mode   = 1'b0;
	logic               dwell_ticks_we = 1'b0;
	logic [7:0]         dwell_ticks    = 8'd1;
	logic               pop            = 1'b0;
	logic               full;
	logic               empty;
	logic [7:0]         digit_sel;
	logic [7:0]         segment_bits;

	// mirror of the display state
	logic [3:0][7:0] seg_pats   = {ssd_pkg::SEG_BLANK, ssd_pkg::SEG_BLANK,
		ssd_pkg::SEG_BLANK, ssd_pkg::SEG_BLANK};
	logic            sign_blank = 1'b1;
	logic [1:0]      scan_pos   = 2'd3;
	logic [7:0]      dwell_cnt  = 8'd0;
	logic [7:0]      dwell_set  = 8'd1;

	display_cmd_t display_cmds[$];
	port_bytes_t  expected_ports[$];

	int tx_idle_pct  = 12;
	int rx_idle_pct  = 74;
	int fail_count   = 0;
	int quiet_cycles = 0;

	seven_segment_scan_driver DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.value          (value),
		.decimal_mode   (decimal_mode),
		.dwell_ticks_we (dwell_ticks_we),
		.dwell_ticks    (dwell_ticks),
		.empty          (empty),
		.pop            (pop),
		.digit_sel      (digit_sel),
		.segment_bits   (segment_bits)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Port bytes shown for one item; updates the mirrored state.
	function automatic port_bytes_t scan_ports(ssd_pkg::op_t op,
		logic signed [17:0] val, logic dec);
		int          sv;
		int          n;
		int          mag;
		int          ip;
		int          frac;
		port_bytes_t r;
		sv = val;
		if (op == ssd_pkg::OP_LOAD) begin
			if (!dec) begin
				n = (sv < 0) ? 0 : (sv > 9999) ? 9999 : sv;
				seg_pats[3] = DIGIT_GLYPH[n / 1000];
				seg_pats[2] = DIGIT_GLYPH[(n / 100) % 10];
				seg_pats[1] = DIGIT_GLYPH[(n / 10) % 10];
				seg_pats[0] = DIGIT_GLYPH[n % 10];
				sign_blank = 1'b0;
			end else begin
				mag = (sv < 0) ? -sv : sv;
				ip = mag / 1000;
				frac = mag % 1000;
				if (ip > 9)
					ip = 9;
				seg_pats[3] = (sv < 0) ? ssd_pkg::SEG_MINUS : ssd_pkg::SEG_BLANK;
				sign_blank = (sv >= 0);
				seg_pats[2] = DIGIT_GLYPH[ip] & ssd_pkg::SEG_DP_MASK;
				seg_pats[1] = DIGIT_GLYPH[frac / 100];
				// second decimal rounds, wrapping to 0 at .x95 and up
				seg_pats[0] = DIGIT_GLYPH[((frac + 5) / 10) % 10];
			end
		end
		if (scan_pos == 2'd3 && sign_blank) begin
			r.dig = ssd_pkg::SEL_NONE;
			r.seg = ssd_pkg::SEG_BLANK;
		end else begin
			r.dig = POS_SELECT[scan_pos];
			r.seg = seg_pats[scan_pos];
		end
		if (op == ssd_pkg::OP_TICK) begin
			// a dwell of 0 advances every tick, same as 1
			if (int'(dwell_cnt) + 1 >= int'(dwell_set)) begin
				dwell_cnt = 8'd0;
				scan_pos = scan_pos - 2'd1;
			end else begin
				dwell_cnt = dwell_cnt + 8'd1;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// sender side
	always @(posedge clk) begin
		display_cmd_t nx;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expected_ports.push_back(scan_ports(ssd_pkg::op_t'(operation), value,
					decimal_mode));
			if (!(push && full)) begin
				if (display_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nx = display_cmds.pop_front();
					push <= 1'b1;
					operation <= nx.op;
					value <= nx.val;
					decimal_mode <= nx.dec;
				end else begin
					push <= 1'b0;
					operation <= 1'($urandom_range(1));
					value <= 18'($urandom);
					decimal_mode <= 1'($urandom_range(1));
				end
			end
		end
	end

	// receiver side
	always @(posedge clk) begin
		port_bytes_t exp_item;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_ports.size() == 0) begin
					flag_mismatch($sformatf("unexpected item digit %h segment %h",
						digit_sel, segment_bits));
				end else begin
					exp_item = expected_ports.pop_front();
					if (digit_sel !== exp_item.dig)
						flag_mismatch($sformatf("digit_sel %h, want %h",
							digit_sel, exp_item.dig));
					if (segment_bits !== exp_item.seg)
						flag_mismatch($sformatf("segment_bits %h, want %h",
							segment_bits, exp_item.seg));
				end
			end
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_cmd(ssd_pkg::op_t op, int val, logic dec);
		display_cmd_t c;
		c.op = op;
		c.val = 18'(val);
		c.dec = dec;
		display_cmds.push_back(c);
	endtask

	// wait until every queued item went through and its result came back;
	// sampled mid-cycle so the driver's updates at the edge are seen
	task automatic settle();
		while (display_cmds.size() != 0 || push || expected_ports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dwell(logic [7:0] v);
		@(posedge clk);
		dwell_ticks_we <= 1'b1;
		dwell_ticks <= v;
		dwell_set = v;
		@(posedge clk);
		dwell_ticks_we <= 1'b0;
	endtask

	function automatic int rand_reading();
		int v;
		int sgn;
		sgn = $urandom_range(1) ? -1 : 1;
		case ($urandom_range(4))
			0: v = int'($urandom_range(199998)) - 99999;
			1: v = int'($urandom_range(9999));
			2: v = int'($urandom_range(20000)) - 10000;
			3: v = sgn * (9990 + int'($urandom_range(20)));
			default: v = sgn * (int'($urandom_range(9)) * 1000 + 990 + int'($urandom_range(9)));
		endcase
		return v;
	endfunction

	initial begin
		int dwell_plan[6];
		int k;
		dwell_plan = '{255, 2, 0, 5, 1, 1};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// blank display scan before any load
		repeat (4) add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 1234, 1'b0);
		repeat (4) add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		// minus shown with all-zero digits
		add_cmd(ssd_pkg::OP_LOAD, -1, 1'b1);
		add_cmd(ssd_pkg::OP_TICK, 131071, 1'b1);
		add_cmd(ssd_pkg::OP_LOAD, 9995, 1'b1);
		add_cmd(ssd_pkg::OP_TICK, -131072, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 12345, 1'b1);
		add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 10000, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, -5, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 9999, 1'b0);
		add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 99999, 1'b1);
		add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, -99999, 1'b1);
		add_cmd(ssd_pkg::OP_TICK, 0, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 0, 1'b1);
		add_cmd(ssd_pkg::OP_LOAD, -99999, 1'b0);
		add_cmd(ssd_pkg::OP_LOAD, 99999, 1'b0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 74 : 0;
			rx_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 12 : 0;
			k = (ph == 5) ? int'($urandom_range(1, 6)) : dwell_plan[ph];
			set_dwell(8'(k));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 35)
					add_cmd(ssd_pkg::OP_LOAD, rand_reading(), 1'($urandom_range(1)));
				else
					add_cmd(ssd_pkg::OP_TICK, int'($urandom), 1'($urandom_range(1)));
			end
			settle();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
